// ===== sv/scli_pkg.sv =====
package scli_pkg;

  // Line buffer geometry: one slot is kept back, as in a C string buffer.
  localparam int unsigned LINE_BUFFER_LEN = 12;
  localparam int unsigned STORE_LIMIT     = LINE_BUFFER_LEN - 1;
  localparam int unsigned MAX_DIGITS      = STORE_LIMIT - 1;
  localparam int unsigned FILL_W          = $clog2(STORE_LIMIT + 1);
  localparam int unsigned IDX_W           = $clog2(STORE_LIMIT);
  localparam int unsigned DIGIT_CNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [31:0] ALIGN_MASK      = 32'h0000_0003;
  localparam logic [3:0]  HEX_LETTER_BASE = 4'hA;

  // Response codes.
  localparam logic [3:0] RC_ADDR    = 4'd0;
  localparam logic [3:0] RC_LEN     = 4'd1;
  localparam logic [3:0] RC_BIN     = 4'd2;
  localparam logic [3:0] RC_HEX     = 4'd3;
  localparam logic [3:0] RC_LE      = 4'd4;
  localparam logic [3:0] RC_BE      = 4'd5;
  localparam logic [3:0] RC_STATS   = 4'd6;
  localparam logic [3:0] RC_START   = 4'd7;
  localparam logic [3:0] RC_UNKNOWN = 4'd8;

  // Control characters.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Decoded hex character.
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } hex_digit_t;

  // Maps one ASCII character to its hex digit value.
  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.digit = 4'h0;
    if (c >= "0" && c <= "9") begin
      r.digit = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      r.digit = 4'(c - "a") + HEX_LETTER_BASE;
    end else if (c >= "A" && c <= "F") begin
      r.digit = 4'(c - "A") + HEX_LETTER_BASE;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/scli_rx_if.sv =====
interface scli_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/scli_rsp_if.sv =====
interface scli_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  response_code;
  logic [31:0] parsed_value;
  logic [31:0] start_address;
  logic [31:0] readout_length;
  logic        hex_output;
  logic        little_endian;
  logic        readout_active;

  modport source (output valid, output response_code, output parsed_value,
                  output start_address, output readout_length, output hex_output,
                  output little_endian, output readout_active, input ready);
  modport sink   (input valid, input response_code, input parsed_value,
                  input start_address, input readout_length, input hex_output,
                  input little_endian, input readout_active, output ready);
endinterface

// ===== sv/serial_command_line_interpreter.sv =====
// Serial command line interpreter.
// rx_i carries received characters, one per transaction. Tab is dropped,
// carriage return or line feed ends a command, and other characters are
// stored in an eleven-byte line buffer (extra characters are lost).
// rsp_o carries one response per non-empty command: the response code, the
// aligned value of an address or length command, and the current settings.
// A plain character is stored as it is taken and rx_i stays ready in the idle state.
// At a delimiter the first buffered character is decoded. Address and length
// commands then walk the buffer one hex digit per cycle through a nibble
// shift register (up to ten digits) before the response is loaded; other
// commands go straight to the response load. rx_i is not ready during that time.
// A waiting response sits in the output register; if rsp_o is stalled when
// the next command finishes, that command holds until the response is taken.
// Reset (rst_ni, asynchronous, active low) clears the line buffer, all
// settings and the output valid.
module serial_command_line_interpreter (
  input  logic             clk_i,
  input  logic             rst_ni,
  scli_rx_if.sink          rx_i,
  scli_rsp_if.source       rsp_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [7:0]                          buf_q [scli_pkg::STORE_LIMIT];
  logic [7:0]                          buf_d [scli_pkg::STORE_LIMIT];
  logic [scli_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [scli_pkg::DIGIT_CNT_W-1:0]    cnt_q, cnt_d;
  logic [7:0]                          cmd_q, cmd_d;
  logic [31:0]                         value_q, value_d;
  logic [31:0]                         addr_q, addr_d;
  logic [31:0]                         len_q, len_d;
  logic                                hex_q, hex_d;
  logic                                endian_q, endian_d;
  logic                                active_q, active_d;
  logic                                out_valid_q, out_valid_d;
  logic [3:0]                          code_q, code_d;
  logic [31:0]                         pval_q, pval_d;
  logic                                rx_fire;
  logic                                slot_free;
  scli_pkg::hex_digit_t                next_digit;
  logic [31:0]                         len_round;

  assign rx_i.ready = (state_q == StIdle);
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign slot_free  = !out_valid_q || rsp_o.ready;
  assign next_digit = scli_pkg::hex_digit(buf_q[1]);
  assign len_round  = (value_q + scli_pkg::ALIGN_MASK) & ~scli_pkg::ALIGN_MASK;

  // Command sequencer: buffer fill, digit walk and response load.
  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    value_d     = value_q;
    addr_d      = addr_q;
    len_d       = len_q;
    hex_d       = hex_q;
    endian_d    = endian_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    code_d      = code_q;
    pval_d      = pval_q;

    unique case (state_q)
      StIdle: begin
        if (rx_fire) begin
          if (rx_i.rx_byte == scli_pkg::CH_CR || rx_i.rx_byte == scli_pkg::CH_LF) begin
            cmd_d   = buf_q[0];
            value_d = '0;
            cnt_d   = '0;
            if (buf_q[0] == scli_pkg::CH_NUL) begin
              // Empty command: nothing to report, just clear the line.
              for (int i = 0; i < scli_pkg::STORE_LIMIT; i++) buf_d[i] = '0;
              fill_d = '0;
            end else if (buf_q[0] == "a" || buf_q[0] == "A" ||
                         buf_q[0] == "l" || buf_q[0] == "L") begin
              state_d = StWalk;
            end else begin
              state_d = StEmit;
            end
          end else if (rx_i.rx_byte != scli_pkg::CH_TAB &&
                       fill_q < scli_pkg::FILL_W'(scli_pkg::STORE_LIMIT)) begin
            buf_d[fill_q[scli_pkg::IDX_W-1:0]] = rx_i.rx_byte;
            fill_d = fill_q + 1'b1;
          end
        end
      end
      StWalk: begin
        // One hex digit per cycle; the buffer shifts down under slot one.
        if (cnt_q == scli_pkg::DIGIT_CNT_W'(scli_pkg::MAX_DIGITS) || !next_digit.valid) begin
          state_d = StEmit;
        end else begin
          value_d = {value_q[27:0], next_digit.digit};
          for (int i = 0; i < scli_pkg::STORE_LIMIT - 1; i++) buf_d[i] = buf_q[i+1];
          buf_d[scli_pkg::STORE_LIMIT-1] = '0;
          cnt_d = cnt_q + 1'b1;
        end
      end
      StEmit: begin
        // Update the settings together with the response register.
        if (slot_free) begin
          out_valid_d = 1'b1;
          pval_d      = '0;
          unique case (cmd_q)
            "a", "A": begin
              addr_d = value_q & ~scli_pkg::ALIGN_MASK;
              pval_d = value_q & ~scli_pkg::ALIGN_MASK;
              code_d = scli_pkg::RC_ADDR;
            end
            "l", "L": begin
              len_d  = len_round;
              pval_d = len_round;
              code_d = scli_pkg::RC_LEN;
            end
            "b", "B": begin
              hex_d  = 1'b0;
              code_d = scli_pkg::RC_BIN;
            end
            "h", "H": begin
              hex_d  = 1'b1;
              code_d = scli_pkg::RC_HEX;
            end
            "e": begin
              endian_d = 1'b1;
              code_d   = scli_pkg::RC_LE;
            end
            "E": begin
              endian_d = 1'b0;
              code_d   = scli_pkg::RC_BE;
            end
            "p", "P": code_d = scli_pkg::RC_STATS;
            "s", "S": begin
              active_d = 1'b1;
              code_d   = scli_pkg::RC_START;
            end
            default: code_d = scli_pkg::RC_UNKNOWN;
          endcase
          for (int i = 0; i < scli_pkg::STORE_LIMIT; i++) buf_d[i] = '0;
          fill_d  = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state and settings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      len_q       <= '0;
      hex_q       <= 1'b0;
      endian_q    <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < scli_pkg::STORE_LIMIT; i++) buf_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      addr_q      <= addr_d;
      len_q       <= len_d;
      hex_q       <= hex_d;
      endian_q    <= endian_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      buf_q       <= buf_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    value_q <= value_d;
    code_q  <= code_d;
    pval_q  <= pval_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.response_code  = code_q;
  assign rsp_o.parsed_value   = pval_q;
  assign rsp_o.start_address  = addr_q;
  assign rsp_o.readout_length = len_q;
  assign rsp_o.hex_output     = hex_q;
  assign rsp_o.little_endian  = endian_q;
  assign rsp_o.readout_active = active_q;

  // Fill count never passes the store limit.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= scli_pkg::FILL_W'(scli_pkg::STORE_LIMIT))
    else $error("line buffer fill count out of range");

  // Stored address and length stay word aligned.
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q[1:0] == 2'b00 && len_q[1:0] == 2'b00)
    else $error("address or length not aligned");

  // An address response carries the address just stored.
  a_addr_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && code_q == scli_pkg::RC_ADDR) |-> pval_q == addr_q)
    else $error("address response does not match stored address");

  // The digit walk never exceeds the digit slots of the buffer.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> cnt_q <= scli_pkg::DIGIT_CNT_W'(scli_pkg::MAX_DIGITS))
    else $error("digit walk ran past the buffer");

  // A new response is loaded only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(code_q) && $stable(pval_q)))
    else $error("pending response was overwritten");

endmodule
